// ----- src/acn_pkg.sv -----
// Shared constants and payload types for the box-pair collision normal unit.
// No dependencies; every other file imports this package.
package acn_pkg;

   localparam int COORD_BITS       = 24;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORM_BITS        = 16;
   localparam int SIZE_BITS        = COORD_BITS - 1;
   // doubled-unit positions and their differences
   localparam int POS_BITS         = COORD_BITS + 3;
   localparam int DIFF_BITS        = COORD_BITS + 4;
   localparam int MAG_BITS         = DIFF_BITS - 1;
   // squaring is split into two halves so each product stays narrow
   localparam int SPLIT            = (MAG_BITS + 1) / 2;
   localparam int HIGH             = MAG_BITS - SPLIT;
   localparam int SQR_BITS         = 2 * MAG_BITS;
   localparam int SUM_BITS         = SQR_BITS + 1;
   // quotient d^2 * 2^(2F+2) / S lies in [0, 2^(2F+2)]
   localparam int QUO_BITS         = 2 * NORMAL_FRAC_BITS + 3;
   localparam int ROOT_STAGES      = NORMAL_FRAC_BITS + 2;
   localparam int ROOT_BITS        = NORMAL_FRAC_BITS + 2;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [NORM_BITS-1:0] NORM_ONE = NORM_BITS'(64'sd1 << NORMAL_FRAC_BITS);
   localparam logic signed [NORM_BITS-1:0] NORM_NEG = -NORM_ONE;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic [SIZE_BITS-1:0]         a_w;
      logic [SIZE_BITS-1:0]         a_h;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic [SIZE_BITS-1:0]         b_w;
      logic [SIZE_BITS-1:0]         b_h;
   } req_type;

   typedef struct packed {
      logic                        overlapping;
      logic                        touching;
      logic signed [NORM_BITS-1:0] normal_x;
      logic signed [NORM_BITS-1:0] normal_y;
      logic                        degenerate;
   } rsp_type;

   // per-transaction control carried alongside the normalize pipeline
   typedef struct packed {
      logic                        ovl;
      logic                        touch;
      logic                        norm;
      logic                        deg;
      logic                        neg_x;
      logic                        neg_y;
      logic signed [NORM_BITS-1:0] nx;
      logic signed [NORM_BITS-1:0] ny;
   } meta_type;

   typedef struct packed {
      meta_type            meta;
      logic [MAG_BITS-1:0] mag_x;
      logic [MAG_BITS-1:0] mag_y;
   } job_type;

endpackage

// ----- src/acn_front.sv -----
// Front end: takes a box pair, does all exact compares and picks the normal case.
// Depends on acn_pkg; feeds acn_queue through a one-entry output register.
module acn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  acn_pkg::req_type req_data,
   output logic             job_valid,
   output acn_pkg::job_type job,
   input  logic             job_ready
);
   import acn_pkg::*;

   logic                        valid_ff, valid_in;
   job_type                     job_ff, job_in;
   logic                        accept;
   logic signed [POS_BITS-1:0]  ax, ay, aw, ah, bx, by, bw, bh;
   logic signed [POS_BITS-1:0]  tpx, tpy, tl, tr, tt, tb;
   logic signed [POS_BITS-1:0]  npx, npy, nl, nr, nt, nb, cx, cy;
   logic signed [DIFF_BITS-1:0] dlx, drx, dly, dry, ix, iy, ox, oy;
   logic                        xin, yin, gx, gy;

   function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [DIFF_BITS-1:0] v);
      logic signed [DIFF_BITS-1:0] a;
      a = (v < 0) ? -v : v;
      return a[MAG_BITS-1:0];
   endfunction

   assign ax = POS_BITS'(req_data.a_x);
   assign ay = POS_BITS'(req_data.a_y);
   assign bx = POS_BITS'(req_data.b_x);
   assign by = POS_BITS'(req_data.b_y);
   assign aw = POS_BITS'({1'b0, req_data.a_w});
   assign ah = POS_BITS'({1'b0, req_data.a_h});
   assign bw = POS_BITS'({1'b0, req_data.b_w});
   assign bh = POS_BITS'({1'b0, req_data.b_h});

   // A centre against B grown by A
   assign tpx = (ax <<< 1) + aw;
   assign tpy = (ay <<< 1) + ah;
   assign tl  = (bx <<< 1) - aw;
   assign tr  = (bx <<< 1) + (bw <<< 1) + aw;
   assign tt  = (by <<< 1) - ah;
   assign tb  = (by <<< 1) + (bh <<< 1) + ah;

   // B centre against A grown by B
   assign npx = (bx <<< 1) + bw;
   assign npy = (by <<< 1) + bh;
   assign nl  = (ax <<< 1) - bw;
   assign nr  = (ax <<< 1) + (aw <<< 1) + bw;
   assign nt  = (ay <<< 1) - bh;
   assign nb  = (ay <<< 1) + (ah <<< 1) + bh;
   assign cx  = (ax <<< 1) + aw;
   assign cy  = (ay <<< 1) + ah;

   assign xin = (npx > nl) && (npx < nr);
   assign yin = (npy > nt) && (npy < nb);
   assign gx  = npx > cx;
   assign gy  = npy > cy;

   assign dlx = DIFF_BITS'(npx) - DIFF_BITS'(nl);
   assign drx = DIFF_BITS'(nr) - DIFF_BITS'(npx);
   assign dly = DIFF_BITS'(npy) - DIFF_BITS'(nt);
   assign dry = DIFF_BITS'(nb) - DIFF_BITS'(npy);
   assign ix  = (dlx < drx) ? dlx : drx;
   assign iy  = (dly < dry) ? dly : dry;
   // outside: nearest edge offset, far edge on ties
   assign ox  = (mag_of(dlx) < mag_of(drx)) ? dlx : -drx;
   assign oy  = (mag_of(dly) < mag_of(dry)) ? dly : -dry;

   always_comb begin
      job_in = '0;
      job_in.meta.ovl = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
      if ((tpx == tl) || (tpx == tr)) begin
         job_in.meta.touch = (tpy >= tt) && (tpy <= tb);
      end else if ((tpy == tt) || (tpy == tb)) begin
         job_in.meta.touch = (tpx >= tl) && (tpx <= tr);
      end
      if (xin && yin) begin
         if (ix < iy) begin
            job_in.meta.nx = gx ? NORM_ONE : NORM_NEG;
         end else if (ix > iy) begin
            job_in.meta.ny = gy ? NORM_ONE : NORM_NEG;
         end else begin
            job_in.meta.norm  = 1'b1;
            job_in.meta.neg_x = !gx;
            job_in.meta.neg_y = !gy;
            job_in.mag_x      = mag_of(ix);
            job_in.mag_y      = mag_of(iy);
         end
      end else if (xin) begin
         job_in.meta.ny = gy ? NORM_ONE : NORM_NEG;
      end else if (yin) begin
         job_in.meta.nx = gx ? NORM_ONE : NORM_NEG;
      end else begin
         job_in.meta.norm  = 1'b1;
         job_in.meta.neg_x = ox < 0;
         job_in.meta.neg_y = oy < 0;
         job_in.mag_x      = mag_of(ox);
         job_in.mag_y      = mag_of(oy);
      end
      job_in.meta.deg = job_in.meta.norm && (job_in.mag_x == '0) && (job_in.mag_y == '0);
   end

   assign busy   = valid_ff && !job_ready;
   assign accept = start && !busy;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (job_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

// ----- src/acn_queue.sv -----
// Short FIFO between the front end and the normalize pipeline.
// Depends on acn_pkg; the back end takes an entry every cycle one is present.
module acn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  acn_pkg::job_type push_job,
   output logic             pop_valid,
   output acn_pkg::job_type pop_job
);
   import acn_pkg::*;

   job_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign push_ready = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid;
   assign pop_job    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/acn_back.sv -----
// Back end: normalizes the offset with a pipelined square, divide and root.
// Depends on acn_pkg; one transaction enters and one leaves every cycle.
module acn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  acn_pkg::job_type in_job,
   output logic             rsp_valid,
   output acn_pkg::rsp_type rsp_data
);
   import acn_pkg::*;

   // square partial products
   logic                   sq_valid_ff;
   meta_type               sq_meta_ff;
   logic [2*HIGH-1:0]      sq_hh_ff [2];
   logic [HIGH+SPLIT-1:0]  sq_hl_ff [2];
   logic [2*SPLIT-1:0]     sq_ll_ff [2];
   logic [MAG_BITS-1:0]    in_mag [2];

   // assembled squares
   logic                   d2_valid_ff;
   meta_type               d2_meta_ff;
   logic [SQR_BITS-1:0]    d2_ff [2];

   // long division stages
   logic                   div_valid_ff [QUO_BITS+1];
   meta_type               div_meta_ff  [QUO_BITS+1];
   logic [SUM_BITS-1:0]    div_sum_ff   [QUO_BITS+1];
   logic [SUM_BITS-1:0]    div_rem_ff   [QUO_BITS+1][2];
   logic [QUO_BITS-1:0]    div_quo_ff   [QUO_BITS+1][2];

   // square root stages
   logic                   rt_valid_ff [ROOT_STAGES+1];
   meta_type               rt_meta_ff  [ROOT_STAGES+1];
   logic [QUO_BITS-1:0]    rt_num_ff   [ROOT_STAGES+1][2];
   logic [QUO_BITS:0]      rt_res_ff   [ROOT_STAGES+1][2];

   logic                   out_valid_ff;
   rsp_type                out_ff, out_in;

   assign in_mag[0] = in_job.mag_x;
   assign in_mag[1] = in_job.mag_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid;
         d2_valid_ff <= sq_valid_ff;
      end
      sq_meta_ff <= in_job.meta;
      d2_meta_ff <= sq_meta_ff;
      for (int k = 0; k < 2; k++) begin
         sq_hh_ff[k] <= in_mag[k][MAG_BITS-1:SPLIT] * in_mag[k][MAG_BITS-1:SPLIT];
         sq_hl_ff[k] <= in_mag[k][MAG_BITS-1:SPLIT] * in_mag[k][SPLIT-1:0];
         sq_ll_ff[k] <= in_mag[k][SPLIT-1:0] * in_mag[k][SPLIT-1:0];
         d2_ff[k]    <= (SQR_BITS'(sq_hh_ff[k]) << (2 * SPLIT))
                      + (SQR_BITS'(sq_hl_ff[k]) << (SPLIT + 1))
                      + SQR_BITS'(sq_ll_ff[k]);
      end
   end

   // load the divider: remainder starts at d^2, divisor is the squared length
   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= d2_valid_ff;
      end
      div_meta_ff[0] <= d2_meta_ff;
      div_sum_ff[0]  <= SUM_BITS'(d2_ff[0]) + SUM_BITS'(d2_ff[1]);
      for (int k = 0; k < 2; k++) begin
         div_rem_ff[0][k] <= SUM_BITS'(d2_ff[k]);
         div_quo_ff[0][k] <= '0;
      end
   end

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
      logic [SUM_BITS:0]   trial [2];
      logic                take  [2];
      logic [SUM_BITS-1:0] rem_in [2];

      always_comb begin
         for (int k = 0; k < 2; k++) begin
            // first step tests the integer bit, later ones shift in a zero
            trial[k]  = (s == 0) ? {1'b0, div_rem_ff[s][k]} : {div_rem_ff[s][k], 1'b0};
            take[k]   = trial[k] >= {1'b0, div_sum_ff[s]};
            rem_in[k] = take[k] ? SUM_BITS'(trial[k] - {1'b0, div_sum_ff[s]})
                                : SUM_BITS'(trial[k]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[s+1] <= 1'b0;
         end else begin
            div_valid_ff[s+1] <= div_valid_ff[s];
         end
         div_meta_ff[s+1] <= div_meta_ff[s];
         div_sum_ff[s+1]  <= div_sum_ff[s];
         for (int k = 0; k < 2; k++) begin
            div_rem_ff[s+1][k] <= rem_in[k];
            div_quo_ff[s+1][k] <= {div_quo_ff[s][k][QUO_BITS-2:0], take[k]};
         end
      end
   end

   always_comb begin
      rt_valid_ff[0] = div_valid_ff[QUO_BITS];
      rt_meta_ff[0]  = div_meta_ff[QUO_BITS];
      for (int k = 0; k < 2; k++) begin
         rt_num_ff[0][k] = div_quo_ff[QUO_BITS][k];
         rt_res_ff[0][k] = '0;
      end
   end

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_root
      localparam logic [QUO_BITS:0] BIT = (QUO_BITS + 1)'(1) << (2 * (ROOT_STAGES - 1 - s));
      logic [QUO_BITS:0] trial [2];
      logic              take  [2];

      always_comb begin
         for (int k = 0; k < 2; k++) begin
            trial[k] = rt_res_ff[s][k] + BIT;
            take[k]  = {1'b0, rt_num_ff[s][k]} >= trial[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[s+1] <= 1'b0;
         end else begin
            rt_valid_ff[s+1] <= rt_valid_ff[s];
         end
         rt_meta_ff[s+1] <= rt_meta_ff[s];
         for (int k = 0; k < 2; k++) begin
            if (take[k]) begin
               rt_num_ff[s+1][k] <= QUO_BITS'({1'b0, rt_num_ff[s][k]} - trial[k]);
               rt_res_ff[s+1][k] <= (rt_res_ff[s][k] >> 1) + BIT;
            end else begin
               rt_num_ff[s+1][k] <= rt_num_ff[s][k];
               rt_res_ff[s+1][k] <= rt_res_ff[s][k] >> 1;
            end
         end
      end
   end

   // largest n with (2n-1)^2 <= quotient is (floor(sqrt) + 1) / 2
   always_comb begin
      logic [ROOT_BITS:0]  root_x, root_y;
      logic [ROOT_BITS-1:0] n_x, n_y;
      meta_type             m;
      m      = rt_meta_ff[ROOT_STAGES];
      root_x = (ROOT_BITS + 1)'(rt_res_ff[ROOT_STAGES][0]) + 1'b1;
      root_y = (ROOT_BITS + 1)'(rt_res_ff[ROOT_STAGES][1]) + 1'b1;
      n_x    = root_x[ROOT_BITS:1];
      n_y    = root_y[ROOT_BITS:1];
      out_in.overlapping = m.ovl;
      out_in.touching    = m.touch;
      out_in.degenerate  = m.deg;
      out_in.normal_x    = m.nx;
      out_in.normal_y    = m.ny;
      if (m.norm && !m.deg) begin
         out_in.normal_x = m.neg_x ? -NORM_BITS'(n_x) : NORM_BITS'(n_x);
         out_in.normal_y = m.neg_y ? -NORM_BITS'(n_y) : NORM_BITS'(n_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= rt_valid_ff[ROOT_STAGES];
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- src/aabb_collision_normal_unit.sv -----
// Top level of the box-pair collision normal unit.
// Depends on acn_pkg, acn_front, acn_queue and acn_back.
//
// Takes one box pair per clock cycle (start while busy is low) and returns one
// result per pair, in order, through the 31-step long division and the 16-step
// square root of the normalize pipeline, both fully pipelined. Each result is
// shown for one cycle on rsp_data with rsp_valid high; the receiver cannot
// stall it. busy only rises if the short queue between the front end and the
// pipeline is full, which a back end that never stalls does not allow in
// steady state.
module aabb_collision_normal_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  acn_pkg::req_type req_data,
   output logic             rsp_valid,
   output acn_pkg::rsp_type rsp_data
);
   import acn_pkg::*;

   logic    job_valid, job_ready, pop_valid;
   job_type job, pop_job;

   acn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   acn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_ready (job_ready),
      .push_job   (job),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   acn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_job    (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.normal_x == '0 && rsp_data.normal_y == '0)
      else $error("degenerate result with nonzero normal");

   a_normal_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |-> rsp_data.normal_x != '0 || rsp_data.normal_y != '0)
      else $error("non-degenerate result with zero normal");

   a_front_hold : assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid && $stable(job))
      else $error("front end dropped a stalled transaction");

endmodule
